FILE: src/bdhr_pkg.sv
// Package for the button debouncer with hold and auto-repeat.
// Holds the shared constants, item codes and structs used by bdhr_core and the top level.
// Has no dependencies.
package bdhr_pkg;

    // Sampling window and vote.
    localparam int WINDOW_LEN     = 5;
    localparam int VOTE_THRESHOLD = 4;
    localparam int CNT_W          = $clog2(WINDOW_LEN + 1);

    // Field widths.
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;
    localparam int TICK_W  = 8;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CHECK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PRESS  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HOLD   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ACCEL  = 3'd4;

    // Button status codes.
    localparam logic [STAT_W-1:0] ST_NONE     = 2'd0;
    localparam logic [STAT_W-1:0] ST_PRESSED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RELEASED = 2'd2;

    // Timer constants.
    localparam logic [TICK_W-1:0] TIMER_SAT    = 8'd254;
    localparam logic [TICK_W-1:0] TIMER_REPEAT = 8'd10;
    localparam logic [TICK_W-1:0] TIMER_ONCE   = 8'd255;
    localparam logic [TICK_W-1:0] FIRST_EXTRA  = 8'd11;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd2;
    localparam logic [CFG_W-1:0] MAX_IV_RST = 8'd50;
    localparam logic [CFG_W-1:0] MIN_IV_RST = 8'd10;
    localparam logic [CFG_W-1:0] STEP_RST   = 8'd5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              level;
        logic [STAT_W-1:0] check_status;
        logic              clear_latch;
        logic [TICK_W-1:0] hold_threshold;
        logic              hold_once;
    } t_item;

    typedef struct packed {
        logic [CFG_W-1:0] max_repeat_interval;
        logic [CFG_W-1:0] min_repeat_interval;
        logic [CFG_W-1:0] repeat_step;
    } t_cfg;

    typedef struct packed {
        logic              hit;
        logic [STAT_W-1:0] debounced;
        logic [STAT_W-1:0] latched_event;
        logic [TICK_W-1:0] hold_ticks;
    } t_result;

endpackage

FILE: src/bdhr_core.sv
// State and update logic of the debouncer: sample window, vote, edge latch,
// hold timer and auto-repeat interval. Depends on bdhr_pkg.
// The result shows the state after the item and is registered by the top level.
module bdhr_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  bdhr_pkg::t_item  i_item,
    input  bdhr_pkg::t_cfg   i_cfg,
    output bdhr_pkg::t_result o_res
);
    import bdhr_pkg::*;

    logic [WINDOW_LEN:0] r_window, n_window;
    logic [CNT_W-1:0]    r_ones, n_ones;
    logic [STAT_W-1:0]   r_stable, n_stable;
    logic [STAT_W-1:0]   r_event, n_event;
    logic [TICK_W-1:0]   r_timer, n_timer;
    logic [CFG_W-1:0]    r_iv, n_iv;
    logic                hit;

    // Shifted window, running count of ones and the vote for a sample.
    logic [WINDOW_LEN:0] win_sh;
    logic [CNT_W-1:0]    ones_sh;
    logic [STAT_W-1:0]   vote_st;
    logic [CFG_W:0]      first_sum;
    logic [CFG_W:0]      floor_sum;

    assign win_sh    = {r_window[WINDOW_LEN-1:0], i_item.level};
    assign ones_sh   = r_ones - CNT_W'(win_sh[WINDOW_LEN]) + CNT_W'(i_item.level);
    assign vote_st   = (int'(ones_sh) >= VOTE_THRESHOLD) ? ST_RELEASED : ST_PRESSED;
    assign first_sum = {1'b0, i_cfg.max_repeat_interval} + {1'b0, FIRST_EXTRA};
    assign floor_sum = {1'b0, i_cfg.min_repeat_interval} + {1'b0, i_cfg.repeat_step};

    // Next state for one item.
    always_comb begin
        n_window = r_window;
        n_ones   = r_ones;
        n_stable = r_stable;
        n_event  = r_event;
        n_timer  = r_timer;
        n_iv     = r_iv;
        hit      = 1'b0;
        unique case (i_item.kind)
            KIND_SAMPLE: begin
                n_window = win_sh;
                n_ones   = ones_sh;
                if (vote_st != r_stable) begin
                    n_stable = vote_st;
                    n_event  = vote_st;
                    if (vote_st == ST_PRESSED) begin
                        n_timer = '0;
                    end
                end else if (vote_st == ST_PRESSED && r_timer < TIMER_SAT) begin
                    n_timer = r_timer + 1'b1;
                end
            end
            KIND_CHECK: begin
                if (r_event == i_item.check_status) begin
                    hit = 1'b1;
                    if (i_item.clear_latch) begin
                        n_event = ST_NONE;
                    end
                end
            end
            KIND_PRESS: begin
                if (r_event == ST_RELEASED && r_timer < TIMER_REPEAT) begin
                    hit     = 1'b1;
                    n_event = ST_NONE;
                end
            end
            KIND_HOLD: begin
                if (r_event == ST_PRESSED && r_timer > i_item.hold_threshold) begin
                    hit     = 1'b1;
                    n_timer = i_item.hold_once ? TIMER_ONCE : TIMER_REPEAT;
                end
            end
            KIND_ACCEL: begin
                if (r_event == ST_RELEASED) begin
                    n_iv = i_cfg.max_repeat_interval;
                end else if (r_timer > r_iv) begin
                    hit     = 1'b1;
                    n_timer = TIMER_REPEAT;
                    if (r_iv == i_cfg.max_repeat_interval) begin
                        // First repeat waits longer; saturate at the top of the range.
                        n_iv = first_sum[CFG_W] ? {CFG_W{1'b1}} : first_sum[CFG_W-1:0];
                    end else if ({1'b0, r_iv} > floor_sum) begin
                        n_iv = r_iv - i_cfg.repeat_step;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // State registers, updated only on an accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '1;
            r_ones   <= CNT_W'(WINDOW_LEN);
            r_stable <= ST_RELEASED;
            r_event  <= ST_NONE;
            r_timer  <= '0;
            r_iv     <= MAX_IV_RST;
        end else if (i_en) begin
            r_window <= n_window;
            r_ones   <= n_ones;
            r_stable <= n_stable;
            r_event  <= n_event;
            r_timer  <= n_timer;
            r_iv     <= n_iv;
        end
    end

    // The result reports the state after the item.
    assign o_res.hit           = hit;
    assign o_res.debounced     = n_stable;
    assign o_res.latched_event = n_event;
    assign o_res.hold_ticks    = n_timer;

    // The running count always matches the window contents.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_ones) == $countones(r_window[WINDOW_LEN-1:0]))
        else $error("ones count disagrees with sample window");

    // The debounced state always follows the vote on the current count.
    a_state_vote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stable == ((int'(r_ones) >= VOTE_THRESHOLD) ? ST_RELEASED : ST_PRESSED))
        else $error("debounced state disagrees with vote");

    // A state change on a sample is always latched as the edge event.
    a_edge_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_item.kind == KIND_SAMPLE && vote_st != r_stable)
        |=> (r_event == r_stable))
        else $error("state change not latched as event");

    // A newly pressed button starts the hold timer from zero.
    a_press_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_stable == ST_PRESSED) |-> (r_timer == '0))
        else $error("hold timer not cleared on press");

endmodule

FILE: src/button_debounce_hold_repeat.sv
// Top level of the button debouncer with hold and auto-repeat queries.
// Holds the configuration registers and the output register; uses bdhr_core and bdhr_pkg.
//
//   channel  | direction | accepted when                      | payload
//   s_axis   | in        | i_s_axis_tvalid && o_s_axis_tready | tuser kind, tdata query fields
//   m_axis   | out       | o_m_axis_tvalid && i_m_axis_tready | tdata result fields
//   cfg      | in        | i_cfg_we                           | i_cfg_idx, i_cfg_wdata
//
// One item per clock unless the output stalls: the state update is combinational, and the
// result appears in the output register on the cycle after acceptance.
// A new item is taken while a result waits, as long as the output register is taken
// in the same cycle; a stalled output holds its result and blocks input.
// Synchronous active-low reset returns the window to all released, the event to none,
// the timer to zero and the registers to 50, 10 and 5.
module button_debounce_hold_repeat (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // level[0], check_status[2:1], clear_latch[3], hold_threshold[11:4],
    // hold_once[12], zero[15:13]
    input  logic [bdhr_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // kind[2:0]
    input  logic [bdhr_pkg::KIND_W-1:0]     i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // hit[0], debounced[2:1], latched_event[4:3], hold_ticks[12:5], zero[15:13]
    output logic [bdhr_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [bdhr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bdhr_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import bdhr_pkg::*;

    t_cfg    r_cfg;
    t_item   item;
    t_result res;
    logic    accept;
    logic    r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_repeat_interval <= MAX_IV_RST;
            r_cfg.min_repeat_interval <= MIN_IV_RST;
            r_cfg.repeat_step         <= STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_IV: r_cfg.max_repeat_interval <= i_cfg_wdata;
                CFG_MIN_IV: r_cfg.min_repeat_interval <= i_cfg_wdata;
                CFG_STEP:   r_cfg.repeat_step         <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Unpack the input item.
    assign item.kind           = i_s_axis_tuser;
    assign item.level          = i_s_axis_tdata[0];
    assign item.check_status   = i_s_axis_tdata[2:1];
    assign item.clear_latch    = i_s_axis_tdata[3];
    assign item.hold_threshold = i_s_axis_tdata[11:4];
    assign item.hold_once      = i_s_axis_tdata[12];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    bdhr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_item  (item),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {3'b000, res.hold_ticks, res.latched_event, res.debounced, res.hit};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Every accepted item yields a result in the next cycle.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted item produced no result");

    // A result that is not taken and not replaced stays in place.
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("stalled result lost or changed");

    // Results carry only legal debounced states.
    a_result_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[2:1] == ST_PRESSED || r_out_data[2:1] == ST_RELEASED))
        else $error("illegal debounced state in result");

endmodule

FILE: bench/button_debounce_hold_repeat_tb.sv
// Self-checking testbench for button_debounce_hold_repeat: a directed run, then
// randomized press sessions under several register settings and idling patterns.
// Depends on bdhr_pkg and the RTL top level only.
module button_debounce_hold_repeat_tb;
    import bdhr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 10;
    localparam int ITEM_QUOTA  = 190;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int IN_FIELDS_W = 13;

    // Codes the block must tolerate but the package does not name.
    localparam logic [KIND_W-1:0]    KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0]    KIND_SPARE_HI = 3'd7;
    localparam logic [STAT_W-1:0]    ST_INVALID    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // level[0], check_status[2:1], clear_latch[3], hold_threshold[11:4],
    // hold_once[12], zero[15:13]
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    // kind[2:0]
    logic [KIND_W-1:0]     i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // hit[0], debounced[2:1], latched_event[4:3], hold_ticks[12:5], zero[15:13]
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;

    // Shadow of the debouncer state and its registers, at reset values.
    logic [WINDOW_LEN:0] btn_window = '1;
    int                  btn_ones = WINDOW_LEN;
    logic [STAT_W-1:0]   btn_state = ST_RELEASED;
    logic [STAT_W-1:0]   btn_event = ST_NONE;
    logic [TICK_W-1:0]   btn_timer = '0;
    logic [CFG_W-1:0]    rpt_interval = MAX_IV_RST;
    logic [CFG_W-1:0]    cfg_max_iv = MAX_IV_RST;
    logic [CFG_W-1:0]    cfg_min_iv = MIN_IV_RST;
    logic [CFG_W-1:0]    cfg_step = STEP_RST;

    t_result button_reports[$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      quiet_cycles = 0;
    int      send_gap_pct = 0;
    int      stall_pct = 0;
    bit      stream_on = 1'b0;

    button_debounce_hold_repeat u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Apply one item to the shadow state and return the report it should produce.
    function automatic t_result advance_button(input t_item it);
        t_result          r;
        logic [WINDOW_LEN:0] shifted;
        logic [STAT_W-1:0] vote;
        logic [CFG_W:0]   widened;
        r.hit = 1'b0;
        case (it.kind)
            KIND_SAMPLE: begin
                shifted = {btn_window[WINDOW_LEN-1:0], it.level};
                btn_window = shifted;
                btn_ones = btn_ones - int'(shifted[WINDOW_LEN]) + int'(it.level);
                vote = (btn_ones >= VOTE_THRESHOLD) ? ST_RELEASED : ST_PRESSED;
                if (vote != btn_state) begin
                    btn_state = vote;
                    btn_event = vote;
                    if (vote == ST_PRESSED)
                        btn_timer = '0;
                end else if (vote == ST_PRESSED && btn_timer < TIMER_SAT) begin
                    btn_timer = btn_timer + 8'd1;
                end
            end
            KIND_CHECK: begin
                if (btn_event == it.check_status) begin
                    if (it.clear_latch)
                        btn_event = ST_NONE;
                    r.hit = 1'b1;
                end
            end
            KIND_PRESS: begin
                if (btn_event == ST_RELEASED && btn_timer < TIMER_REPEAT) begin
                    btn_event = ST_NONE;
                    r.hit = 1'b1;
                end
            end
            KIND_HOLD: begin
                if (btn_event == ST_PRESSED && btn_timer > it.hold_threshold) begin
                    btn_timer = it.hold_once ? TIMER_ONCE : TIMER_REPEAT;
                    r.hit = 1'b1;
                end
            end
            KIND_ACCEL: begin
                if (btn_event == ST_RELEASED) begin
                    rpt_interval = cfg_max_iv;
                end else if (btn_timer > rpt_interval) begin
                    // The first repeat lengthens the interval, later ones shrink it while it stays above min plus step.
                    if (rpt_interval == cfg_max_iv) begin
                        widened = {1'b0, cfg_max_iv} + {1'b0, FIRST_EXTRA};
                        rpt_interval = widened[CFG_W] ? '1 : widened[CFG_W-1:0];
                    end else if ({1'b0, rpt_interval} > {1'b0, cfg_min_iv} + {1'b0, cfg_step}) begin
                        rpt_interval = rpt_interval - cfg_step;
                    end
                    btn_timer = TIMER_REPEAT;
                    r.hit = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.debounced = btn_state;
        r.latched_event = btn_event;
        r.hold_ticks = btn_timer;
        return r;
    endfunction

    function automatic t_item item_of(input logic [KIND_W-1:0] kind, input logic level,
                                      input logic [STAT_W-1:0] chk, input logic clr,
                                      input logic [TICK_W-1:0] thr, input logic once);
        t_item it;
        it.kind = kind;
        it.level = level;
        it.check_status = chk;
        it.clear_latch = clr;
        it.hold_threshold = thr;
        it.hold_once = once;
        return it;
    endfunction

    // Random query fields; thresholds lean small so that hold queries can hit.
    function automatic t_item random_item(input logic [KIND_W-1:0] kind, input logic level);
        t_item       it;
        int unsigned pick;
        logic [31:0] bits;
        bits = $urandom;
        pick = $urandom_range(2);
        it.kind = kind;
        it.level = level;
        it.check_status = (bits[31:28] == 4'd0) ? ST_INVALID : pick[STAT_W-1:0];
        it.clear_latch = bits[0];
        it.hold_once = bits[1];
        if (bits[3:2] == 2'd0) begin
            it.hold_threshold = bits[15:8];
        end else begin
            pick = $urandom_range(80);
            it.hold_threshold = pick[TICK_W-1:0];
        end
        return it;
    endfunction

    function automatic logic [KIND_W-1:0] query_kind();
        case ($urandom_range(9))
            0, 1: return KIND_CHECK;
            2: return KIND_PRESS;
            3, 4, 5: return KIND_HOLD;
            default: return KIND_ACCEL;
        endcase
    endfunction

    // Offer one item, with an optional idle gap first, and record its expected report.
    task automatic send_item(input t_item it);
        int gap;
        gap = 0;
        while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
            gap++;
        if (gap > 0) begin
            if (stream_on) begin
                i_s_axis_tvalid <= 1'b0;
                stream_on = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        stream_on = 1'b1;
        i_s_axis_tdata <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, it.hold_once, it.hold_threshold,
                           it.clear_latch, it.check_status, it.level};
        i_s_axis_tuser <= it.kind;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        button_reports.push_back(advance_button(it));
        if (it.kind <= KIND_ACCEL)
            items_sent++;
    endtask

    // Stop offering items and wait until every expected report has arrived.
    task automatic wait_all_reports();
        if (stream_on) begin
            i_s_axis_tvalid <= 1'b0;
            stream_on = 1'b0;
        end
        while (button_reports.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_IV: cfg_max_iv = value;
            CFG_MIN_IV: cfg_min_iv = value;
            CFG_STEP: cfg_step = value;
            default: begin
            end
        endcase
    endtask

    task automatic set_config(input logic [CFG_W-1:0] max_iv, input logic [CFG_W-1:0] min_iv,
                              input logic [CFG_W-1:0] step);
        write_reg(CFG_MAX_IV, max_iv);
        write_reg(CFG_MIN_IV, min_iv);
        write_reg(CFG_STEP, step);
    endtask

    // Bouncy press, held run (with queries mixed in unless it is long), bouncy release, trailing queries.
    task automatic press_session(input bit long_hold);
        int  hold_len;
        bit  with_queries;
        with_queries = 1'b1;
        repeat ($urandom_range(4)) send_item(random_item(KIND_SAMPLE, $urandom_range(1) == 1));
        if (long_hold || $urandom_range(14) == 0) begin
            // Long enough to pin the timer at its ceiling.
            hold_len = $urandom_range(260, 300);
            with_queries = 1'b0;
        end else if ($urandom_range(2) == 0) begin
            hold_len = $urandom_range(8);
        end else begin
            hold_len = $urandom_range(9, 80);
        end
        repeat (hold_len) begin
            send_item(random_item(KIND_SAMPLE, $urandom_range(15) == 0));
            if (with_queries && $urandom_range(2) == 0)
                send_item(random_item(query_kind(), $urandom_range(1) == 1));
        end
        repeat ($urandom_range(3)) send_item(random_item(KIND_SAMPLE, $urandom_range(1) == 1));
        repeat (WINDOW_LEN) send_item(random_item(KIND_SAMPLE, 1'b1));
        repeat ($urandom_range(3)) send_item(random_item(query_kind(), $urandom_range(1) == 1));
    endtask

    // Mostly press sessions, some raw noise, and the odd full pause.
    task automatic run_random(input int quota);
        int          target;
        int unsigned pick;
        target = items_sent + quota;
        while (items_sent < target) begin
            case ($urandom_range(9))
                0: begin
                    repeat ($urandom_range(1, 8)) begin
                        pick = $urandom_range(7);
                        send_item(random_item(pick[KIND_W-1:0], $urandom_range(1) == 1));
                    end
                end
                1: begin
                    if ($urandom_range(3) == 0)
                        wait_all_reports();
                    else
                        press_session(1'b0);
                end
                default: press_session(1'b0);
            endcase
        end
        wait_all_reports();
    endtask

    // Reset defaults, every item kind, and the corner cases of the latch and timer.
    task automatic test_directed_cases();
        send_gap_pct = 0;
        stall_pct = 0;
        send_item(item_of(KIND_CHECK, 1'b0, ST_NONE, 1'b0, 8'd0, 1'b0));
        send_item(item_of(KIND_CHECK, 1'b1, ST_INVALID, 1'b1, 8'hFF, 1'b1));
        send_item(item_of(KIND_SPARE_HI, 1'b1, ST_INVALID, 1'b1, 8'hFF, 1'b1));
        repeat (2) send_item(item_of(KIND_SAMPLE, 1'b0, ST_NONE, 1'b0, 8'd0, 1'b0));
        send_item(item_of(KIND_CHECK, 1'b0, ST_PRESSED, 1'b0, 8'd0, 1'b0));
        send_item(item_of(KIND_HOLD, 1'b0, ST_NONE, 1'b0, 8'd0, 1'b1));
        send_item(item_of(KIND_SAMPLE, 1'b0, ST_NONE, 1'b0, 8'd0, 1'b0));
        send_item(item_of(KIND_HOLD, 1'b0, ST_NONE, 1'b0, 8'd0, 1'b1));
        // The timer sits at its fire-once value and a further sample must not move it.
        send_item(item_of(KIND_SAMPLE, 1'b0, ST_NONE, 1'b0, 8'd0, 1'b0));
        send_item(item_of(KIND_HOLD, 1'b0, ST_NONE, 1'b0, 8'hFF, 1'b0));
        send_item(item_of(KIND_ACCEL, 1'b0, ST_NONE, 1'b0, 8'd0, 1'b0));
        send_item(item_of(KIND_HOLD, 1'b0, ST_NONE, 1'b0, 8'd9, 1'b0));
        repeat (4) send_item(item_of(KIND_SAMPLE, 1'b1, ST_NONE, 1'b0, 8'd0, 1'b0));
        send_item(item_of(KIND_PRESS, 1'b0, ST_NONE, 1'b0, 8'd0, 1'b0));
        send_item(item_of(KIND_ACCEL, 1'b0, ST_NONE, 1'b0, 8'd0, 1'b0));
        // A short press followed by a press query that should hit.
        repeat (2) send_item(item_of(KIND_SAMPLE, 1'b0, ST_NONE, 1'b0, 8'd0, 1'b0));
        repeat (4) send_item(item_of(KIND_SAMPLE, 1'b1, ST_NONE, 1'b0, 8'd0, 1'b0));
        send_item(item_of(KIND_PRESS, 1'b0, ST_NONE, 1'b0, 8'd0, 1'b0));
        wait_all_reports();
    endtask

    task automatic test_free_flow();
        send_gap_pct = 0;
        stall_pct = 0;
        press_session(1'b1);
        run_random(ITEM_QUOTA);
    endtask

    task automatic test_sender_gaps();
        set_config(8'd12, 8'd3, 8'd2);
        send_gap_pct = 77;
        stall_pct = 0;
        run_random(ITEM_QUOTA);
    endtask

    task automatic test_receiver_stalls();
        set_config(8'd0, 8'd0, 8'd0);
        send_gap_pct = 0;
        stall_pct = 77;
        run_random(ITEM_QUOTA);
    endtask

    task automatic test_both_idle();
        set_config(8'd20, 8'd5, 8'd7);
        send_gap_pct = 10;
        stall_pct = 10;
        run_random(ITEM_QUOTA);
    endtask

    // Register extremes, plus a write to an index that has no register behind it.
    task automatic test_register_extremes();
        logic [31:0] junk;
        junk = $urandom;
        send_gap_pct = 0;
        stall_pct = 0;
        set_config(8'd244, 8'hFF, 8'hFF);
        write_reg(CFG_SPARE, junk[CFG_W-1:0]);
        run_random(ITEM_QUOTA / 2);
        set_config(8'd9, 8'd0, 8'hFF);
        write_reg(CFG_SPARE, ~junk[CFG_W-1:0]);
        run_random(ITEM_QUOTA / 2);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare every accepted report with the oldest expectation; randomize receiver stalls.
    always @(posedge i_clk) begin : check_reports
        t_result               want;
        logic [OUT_DATA_W-1:0] got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (button_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, got %0h", $time, got);
                mismatches++;
            end else begin
                want = button_reports.pop_front();
                check_field("hit", 8'(want.hit), 8'(got[0]));
                check_field("debounced", 8'(want.debounced), 8'(got[2:1]));
                check_field("latched_event", 8'(want.latched_event), 8'(got[4:3]));
                check_field("hold_ticks", want.hold_ticks, got[12:5]);
                check_field("padding", 8'd0, 8'(got[OUT_DATA_W-1:IN_FIELDS_W]));
            end
        end
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: too long without any item moving on either side ends the run.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("button_debounce_hold_repeat_tb NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_free_flow();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_register_extremes();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (button_reports.size() != 0) begin
            $display("%0t: %0d reports never arrived", $time, button_reports.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("button_debounce_hold_repeat_tb OK");
        else
            $display("button_debounce_hold_repeat_tb NOT OK");
        $finish;
    end

endmodule
